### sv/tclru_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the tile cache LRU table.
package tclru_pkg;

  localparam int DEF_ENTRIES = 64;

  localparam int MODE_W   = 2;
  localparam int SRC_W    = 8;
  localparam int GRID_W   = 20;
  localparam int ZOOM_W   = 5;
  localparam int KEY_W    = SRC_W + GRID_W + GRID_W + ZOOM_W;
  localparam int HANDLE_W = 16;
  localparam int STAMP_W  = 32;
  localparam int TOTAL_W  = 32;
  localparam int COUNT_W  = 7;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_LOOKUP = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_CLEAR  = 2'd2;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
    logic [STAMP_W-1:0]  stamp;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture the input beat, restart scan trackers
    logic scan_rd;   // read entry at scan address, advance address
    logic clr_wr;    // invalidate entry at scan address, advance address
    logic decide;    // register the insert/lookup decision
    logic wr_evict;  // invalidate the oldest entry when required
    logic wr_slot;   // write the target entry when required
    logic finish;    // update counters, load the result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic addr_last;
  } sts_t;

endpackage

### sv/tclru_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine and handshake control for the tile cache LRU table.
module tclru_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tclru_pkg::mode_t  in_mode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output tclru_pkg::cmd_t   cmd,
  input  tclru_pkg::sts_t   sts
);

  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_SCAN  = 9'b000000100,
    ST_DRAIN = 9'b000001000,
    ST_DEC   = 9'b000010000,
    ST_WRE   = 9'b000100000,
    ST_WRS   = 9'b001000000,
    ST_CLR   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.addr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_mode inside {tclru_pkg::MODE_LOOKUP, tclru_pkg::MODE_INSERT}) begin
            state_nxt = ST_SCAN;
          end else if (in_mode == tclru_pkg::MODE_CLEAR) begin
            state_nxt = ST_CLR;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.addr_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DEC;
      ST_DEC: begin
        cmd.decide = 1'b1;
        state_nxt  = ST_WRE;
      end
      ST_WRE: begin
        cmd.wr_evict = 1'b1;
        state_nxt    = ST_WRS;
      end
      ST_WRS: begin
        cmd.wr_slot = 1'b1;
        state_nxt   = ST_FIN;
      end
      ST_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.addr_last) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/tclru_dpath.sv
`timescale 1ns / 1ps
// Entry memory, scan trackers, decision logic, counters and result register.
module tclru_dpath #(
  parameter int ENTRIES = tclru_pkg::DEF_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tclru_pkg::mode_t                   in_mode,
  input  logic [tclru_pkg::SRC_W-1:0]        in_source_id,
  input  logic [tclru_pkg::GRID_W-1:0]       in_grid_x,
  input  logic [tclru_pkg::GRID_W-1:0]       in_grid_y,
  input  logic [tclru_pkg::ZOOM_W-1:0]       in_zoom_level,
  input  logic [tclru_pkg::HANDLE_W-1:0]     in_tile_handle,
  input  logic                               in_memory_low,
  input  tclru_pkg::cmd_t                    cmd,
  output tclru_pkg::sts_t                    sts,
  output logic                               out_hit,
  output logic [tclru_pkg::HANDLE_W-1:0]     out_found_handle,
  output logic                               out_evicted,
  output logic [tclru_pkg::COUNT_W-1:0]      out_entry_count,
  output logic [tclru_pkg::TOTAL_W-1:0]      out_hit_total,
  output logic [tclru_pkg::TOTAL_W-1:0]      out_miss_total
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int LIVE_W = $clog2(ENTRIES + 1);

  tclru_pkg::entry_t mem [ENTRIES];

  // captured beat
  tclru_pkg::mode_t                  mode_r;
  logic [tclru_pkg::KEY_W-1:0]       key_r;
  logic [tclru_pkg::HANDLE_W-1:0]    handle_r;
  logic                              mem_low_r;

  // scan
  logic [IDX_W-1:0]                  addr_r;
  logic                              rd_vld_r;
  logic [IDX_W-1:0]                  rd_idx_r;
  tclru_pkg::entry_t                 rd_data_r;

  logic                              match_found_r;
  logic [IDX_W-1:0]                  match_idx_r;
  logic [tclru_pkg::HANDLE_W-1:0]    match_handle_r;
  logic                              free_found_r;
  logic [IDX_W-1:0]                  free_idx_r;
  logic                              old_found_r;
  logic [IDX_W-1:0]                  old_idx_r;
  logic [tclru_pkg::STAMP_W-1:0]     old_age_r;

  // decision
  logic                              dec_hit_r, dec_evict_r, dec_alloc_r;
  logic                              dec_slot_wr_r, dec_evict_wr_r;
  logic [IDX_W-1:0]                  dec_slot_r;

  // state counters
  logic [LIVE_W-1:0]                 live_r;
  logic [tclru_pkg::STAMP_W-1:0]     clock_r;
  logic [tclru_pkg::TOTAL_W-1:0]     hits_r, misses_r;

  // result register
  logic                              res_hit_r, res_evicted_r;
  logic [tclru_pkg::HANDLE_W-1:0]    res_handle_r;
  logic [tclru_pkg::COUNT_W-1:0]     res_count_r;
  logic [tclru_pkg::TOTAL_W-1:0]     res_hits_r, res_misses_r;

  logic                              is_lookup, is_insert, is_clear;
  logic                              key_eq;
  logic [tclru_pkg::STAMP_W-1:0]     age;
  logic                              evict_c, use_match, free_ok;
  logic [IDX_W-1:0]                  free_c, slot_c;
  logic                              slot_wr_c, alloc_c, hit_c, evict_wr_c;
  logic                              we;
  logic [IDX_W-1:0]                  wa;
  tclru_pkg::entry_t                 wd;
  logic [LIVE_W-1:0]                 live_fin;
  logic [tclru_pkg::TOTAL_W-1:0]     hits_nxt, misses_nxt;

  assign is_lookup = (mode_r == tclru_pkg::MODE_LOOKUP);
  assign is_insert = (mode_r == tclru_pkg::MODE_INSERT);
  assign is_clear  = (mode_r == tclru_pkg::MODE_CLEAR);

  assign sts.addr_last = (addr_r == IDX_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_mode;
      key_r     <= {in_source_id, in_grid_x, in_grid_y, in_zoom_level};
      handle_r  <= in_tile_handle;
      mem_low_r <= in_memory_low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r   <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.scan_rd || cmd.clr_wr) begin
        addr_r <= sts.addr_last ? '0 : addr_r + 1'b1;
      end
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_data_r <= mem[addr_r];
      rd_idx_r  <= addr_r;
    end
  end

  assign key_eq = (rd_data_r.key == key_r);
  assign age    = clock_r - rd_data_r.stamp;

  // first match, first free slot, oldest valid entry (ties to lowest index)
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      old_found_r   <= 1'b0;
    end else if (rd_vld_r) begin
      if (rd_data_r.valid) begin
        if (!match_found_r && key_eq) begin
          match_found_r  <= 1'b1;
          match_idx_r    <= rd_idx_r;
          match_handle_r <= rd_data_r.handle;
        end
        if (!old_found_r || age > old_age_r) begin
          old_found_r <= 1'b1;
          old_idx_r   <= rd_idx_r;
          old_age_r   <= age;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  always_comb begin
    evict_c = is_insert && old_found_r &&
              (mem_low_r || (!match_found_r && live_r == LIVE_W'(ENTRIES)));
    // a forced eviction may remove the matching entry itself
    use_match = match_found_r && !(evict_c && old_idx_r == match_idx_r);
    free_ok   = free_found_r || evict_c;
    if (evict_c && (!free_found_r || old_idx_r < free_idx_r)) begin
      free_c = old_idx_r;
    end else begin
      free_c = free_idx_r;
    end
    hit_c     = 1'b0;
    slot_c    = match_idx_r;
    slot_wr_c = 1'b0;
    alloc_c   = 1'b0;
    if (is_lookup) begin
      hit_c     = match_found_r;
      slot_wr_c = match_found_r;
    end else if (is_insert) begin
      slot_c    = use_match ? match_idx_r : free_c;
      slot_wr_c = use_match || free_ok;
      alloc_c   = !use_match && free_ok;
    end
    evict_wr_c = evict_c && !(slot_wr_c && slot_c == old_idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      dec_hit_r      <= 1'b0;
      dec_evict_r    <= 1'b0;
      dec_alloc_r    <= 1'b0;
      dec_slot_wr_r  <= 1'b0;
      dec_evict_wr_r <= 1'b0;
    end else if (cmd.decide) begin
      dec_hit_r      <= hit_c;
      dec_evict_r    <= evict_c;
      dec_alloc_r    <= alloc_c;
      dec_slot_wr_r  <= slot_wr_c;
      dec_evict_wr_r <= evict_wr_c;
      dec_slot_r     <= slot_c;
    end
  end

  always_comb begin
    we = 1'b0;
    wa = addr_r;
    wd = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.wr_evict && dec_evict_wr_r) begin
      we = 1'b1;
      wa = old_idx_r;
    end else if (cmd.wr_slot && dec_slot_wr_r) begin
      we        = 1'b1;
      wa        = dec_slot_r;
      wd.valid  = 1'b1;
      wd.key    = key_r;
      wd.handle = is_lookup ? match_handle_r : handle_r;
      wd.stamp  = clock_r;
    end
  end

  always_comb begin
    if (is_clear) begin
      live_fin = '0;
    end else begin
      live_fin = live_r - LIVE_W'(dec_evict_r) + LIVE_W'(dec_alloc_r);
    end
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (is_lookup) begin
      if (dec_hit_r) hits_nxt = hits_r + 1'b1;
      else           misses_nxt = misses_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      clock_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
    end else if (cmd.finish) begin
      live_r   <= live_fin;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      if (dec_slot_wr_r) clock_r <= clock_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_hit_r     <= dec_hit_r;
      res_handle_r  <= dec_hit_r ? match_handle_r : '0;
      res_evicted_r <= dec_evict_r;
      res_count_r   <= tclru_pkg::COUNT_W'(live_fin);
      res_hits_r    <= hits_nxt;
      res_misses_r  <= misses_nxt;
    end
  end

  assign out_hit          = res_hit_r;
  assign out_found_handle = res_handle_r;
  assign out_evicted      = res_evicted_r;
  assign out_entry_count  = res_count_r;
  assign out_hit_total    = res_hits_r;
  assign out_miss_total   = res_misses_r;

endmodule

### sv/tile_cache_lru_table.sv
`timescale 1ns / 1ps
// Top level of the tile cache LRU table: fully associative tile handle table.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    mode, key fields, handle, memory_low
//  out_     output     out_valid / out_ready  hit, handle, evicted, count, totals
//
// Steps: lookup and insert run a sequential scan of the single-read-port entry
//   memory, then the decide, two write and finish steps. Clear sweeps every
//   entry and then finishes; mode 3 goes straight to its finish step.
// Reset: synchronous, active low. After reset a clearing pass invalidates every
//   entry; in_ready stays low until it is done.
// Stalls: the result register holds one beat; the next input beat is accepted
//   while it waits, and that item only stalls at its finish step.
module tile_cache_lru_table #(
  parameter int ENTRIES = tclru_pkg::DEF_ENTRIES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  tclru_pkg::mode_t                   in_mode,
  input  logic [tclru_pkg::SRC_W-1:0]        in_source_id,
  input  logic [tclru_pkg::GRID_W-1:0]       in_grid_x,
  input  logic [tclru_pkg::GRID_W-1:0]       in_grid_y,
  input  logic [tclru_pkg::ZOOM_W-1:0]       in_zoom_level,
  input  logic [tclru_pkg::HANDLE_W-1:0]     in_tile_handle,
  input  logic                               in_memory_low,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [tclru_pkg::HANDLE_W-1:0]     out_found_handle,
  output logic                               out_evicted,
  output logic [tclru_pkg::COUNT_W-1:0]      out_entry_count,
  output logic [tclru_pkg::TOTAL_W-1:0]      out_hit_total,
  output logic [tclru_pkg::TOTAL_W-1:0]      out_miss_total
);

  tclru_pkg::cmd_t cmd;
  tclru_pkg::sts_t sts;

  // sequencing: init sweep, scan, decide, writes, result hand-off
  tclru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // entry memory, trackers, counters and result payload
  tclru_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mode          (in_mode),
    .in_source_id     (in_source_id),
    .in_grid_x        (in_grid_x),
    .in_grid_y        (in_grid_y),
    .in_zoom_level    (in_zoom_level),
    .in_tile_handle   (in_tile_handle),
    .in_memory_low    (in_memory_low),
    .cmd              (cmd),
    .sts              (sts),
    .out_hit          (out_hit),
    .out_found_handle (out_found_handle),
    .out_evicted      (out_evicted),
    .out_entry_count  (out_entry_count),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total)
  );

  // one item in flight: an accepted beat keeps the input closed next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // at most one memory access command per cycle
  a_mem_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.scan_rd, cmd.clr_wr, cmd.wr_evict, cmd.wr_slot}))
    else $error("conflicting memory commands");

  // a result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  // hit handle only on a hit
  a_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_found_handle == '0))
    else $error("handle reported without a hit");

endmodule
